@@ hw/rtl/srpw_pkg.sv @@
// Shared types and constants for the sample rate to pitch word calculator.
package srpw_pkg;

	localparam int unsigned RATE_W      = 16;
	localparam int unsigned PITCH_W     = 15;
	localparam int unsigned BPB_W       = 15;
	localparam int unsigned FNS_W       = 10;
	localparam int unsigned OCT_W       = 5;
	localparam int unsigned OCT_FIELD_W = 4;
	localparam int unsigned OCT_MAX     = 16;
	localparam int unsigned QUO_W       = 12;
	localparam int unsigned BASE_W      = 16;
	localparam int unsigned NUM_W       = RATE_W + FNS_W;
	localparam int unsigned CMP_W       = BASE_W + QUO_W;
	localparam int unsigned DIVX_W      = RATE_W + 1;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W     = 19;
	localparam int unsigned PROD_W      = DIVX_W + RECIP_W;

	localparam logic [BASE_W-1:0] SYS_FREQ   = 16'd44100;
	localparam int unsigned       TABLE_SIZE = 256;
	localparam logic [RATE_W-1:0] RATE_LOW_LIM = RATE_W'(44100 / TABLE_SIZE);

	localparam logic [DIVX_W-1:0] FRAMES_PAL  = DIVX_W'(50);
	localparam logic [DIVX_W-1:0] FRAMES_NTSC = DIVX_W'(60);
	localparam logic [RECIP_W-1:0] RECIP_PAL  = RECIP_W'((64'd1 << RECIP_SHIFT) / 50);
	localparam logic [RECIP_W-1:0] RECIP_NTSC = RECIP_W'((64'd1 << RECIP_SHIFT) / 60);

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic [NUM_W-1:0]  num;
		logic [BASE_W-1:0] divisor;
		logic [OCT_W-1:0]  oct;
		logic              too_low;
		logic [DIVX_W-1:0] bytes;
		logic              pal;
	} srpw_entry_t;

	// Contents of one divider pipeline stage.
	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [QUO_W-1:0]  quo;
		logic [BASE_W-1:0] divisor;
		logic [OCT_W-1:0]  oct;
		logic              too_low;
		logic [PROD_W-1:0] prod;
		logic [DIVX_W-1:0] bytes;
		logic              pal;
		logic [BPB_W-1:0]  bpb;
	} srpw_stage_t;

endpackage

@@ hw/rtl/sample_rate_pitch_word_calc_top.sv @@
// Sample rate to pitch word calculator, top level.
// Throughput: one item per cycle unless out_stall holds the pipeline; the back end is a 12-stage
// divider pipeline, one quotient bit each. Accepted items pass through the queue, then each stage.
// A 4-entry queue (by default) between front and back absorbs output stalls.
// Reset clears the queue, all pipeline valids and sets region_pal to 0 (60 frames per second).
module sample_rate_pitch_word_calc_top #(
	parameter int unsigned QUEUE_DEPTH = srpw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srpw_pkg::RATE_W-1:0]  sample_rate,
	input  logic                         is_8bit,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [srpw_pkg::PITCH_W-1:0] pitch_word,
	output logic [srpw_pkg::BPB_W-1:0]   frame_bytes,
	output logic                         rate_too_low
);
	import srpw_pkg::*;

	logic        region_pal_q;
	srpw_entry_t entry;
	srpw_entry_t head;
	logic        full;
	logic        empty;
	logic        push;
	logic        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_pal_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			region_pal_q <= cfg_data;
		end
	end

	assign in_stall = full;
	assign push     = in_valid && !full;

	srpw_front u_front (
		.sample_rate (sample_rate),
		.is_8bit     (is_8bit),
		.region_pal  (region_pal_q),
		.entry       (entry)
	);

	srpw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (head)
	);

	srpw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pitch_word   (pitch_word),
		.frame_bytes  (frame_bytes),
		.rate_too_low (rate_too_low)
	);

endmodule

@@ hw/rtl/srpw_front.sv @@
// Front end: classifies a sample rate into octave, base frequency and divider operands.
module srpw_front (
	input  logic [srpw_pkg::RATE_W-1:0] sample_rate,
	input  logic                        is_8bit,
	input  logic                        region_pal,
	output srpw_pkg::srpw_entry_t       entry
);
	import srpw_pkg::*;

	logic [OCT_W-1:0]  oct;
	logic [BASE_W-1:0] base;
	logic              frac_ok;

	// The quotient 44100/(rate+1) reaches 2^(k-1) exactly when rate is below 44100>>(k-1),
	// so the octave is the highest such k and no division is needed.
	always_comb begin
		oct = '0;
		for (int k = 1; k <= OCT_MAX; k++) begin
			if (sample_rate < BASE_W'(SYS_FREQ >> (k - 1))) begin
				oct = OCT_W'(k);
			end
		end
	end

	assign base    = SYS_FREQ >> oct;
	assign frac_ok = (base != '0) && (sample_rate >= base);

	// When there is no fraction, a zero dividend over a divisor of one yields zero.
	always_comb begin
		entry.divisor = frac_ok ? base : BASE_W'(1);
		entry.num     = frac_ok ? {sample_rate - base, FNS_W'(0)} : '0;
		entry.oct     = oct;
		entry.too_low = sample_rate < RATE_LOW_LIM;
		entry.bytes   = is_8bit ? {1'b0, sample_rate} : {sample_rate, 1'b0};
		entry.pal     = region_pal;
	end

endmodule

@@ hw/rtl/srpw_fifo.sv @@
// Short queue between the classifying front end and the divider back end.
module srpw_fifo #(
	parameter int unsigned DEPTH = srpw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  srpw_pkg::srpw_entry_t wdata,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output srpw_pkg::srpw_entry_t rdata
);
	import srpw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	srpw_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/srpw_back.sv @@
// Back end: pipelined restoring divider for the fraction, frame-rate divide and output stage.
module srpw_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srpw_pkg::srpw_entry_t        head,
	input  logic                         head_valid,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [srpw_pkg::PITCH_W-1:0] pitch_word,
	output logic [srpw_pkg::BPB_W-1:0]   frame_bytes,
	output logic                         rate_too_low
);
	import srpw_pkg::*;

	srpw_stage_t      stg_s [QUO_W];
	logic [QUO_W-1:0] vld_s;
	srpw_stage_t      nxt [QUO_W];
	logic             adv;
	logic [OCT_W-1:0] oct_neg;

	// The whole pipeline moves together; the last stage doubles as the output register.
	assign adv = !vld_s[QUO_W-1] || !out_stall;
	assign pop = adv && head_valid;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		srpw_stage_t       cur;
		logic [CMP_W-1:0]  rem_w;
		logic [CMP_W-1:0]  dsh;
		logic [PROD_W-1:0] prod_n;
		logic [BPB_W-1:0]  bpb_n;

		if (k == 0) begin : g_load
			always_comb begin
				cur         = '0;
				cur.rem     = head.num;
				cur.divisor = head.divisor;
				cur.oct     = head.oct;
				cur.too_low = head.too_low;
				cur.bytes   = head.bytes;
				cur.pal     = head.pal;
			end
			assign prod_n = PROD_W'(cur.bytes) * PROD_W'(cur.pal ? RECIP_PAL : RECIP_NTSC);
			assign bpb_n  = cur.bpb;
		end else if (k == 1) begin : g_fix
			logic [BPB_W-1:0]  q0;
			logic [DIVX_W-1:0] frames;
			logic [DIVX_W-1:0] rem_b;

			assign cur    = stg_s[k-1];
			assign prod_n = cur.prod;
			// The reciprocal product undershoots by at most one, so one compare fixes it.
			assign q0     = BPB_W'(cur.prod[PROD_W-1:RECIP_SHIFT]);
			assign frames = cur.pal ? FRAMES_PAL : FRAMES_NTSC;
			assign rem_b  = cur.bytes - DIVX_W'(DIVX_W'(q0) * frames);
			assign bpb_n  = (rem_b >= frames) ? q0 + 1'b1 : q0;
		end else begin : g_chain
			assign cur    = stg_s[k-1];
			assign prod_n = cur.prod;
			assign bpb_n  = cur.bpb;
		end

		// Each stage settles one quotient bit, most significant first.
		always_comb begin
			rem_w    = CMP_W'(cur.rem);
			dsh      = CMP_W'(cur.divisor) << (QUO_W - 1 - k);
			nxt[k]   = cur;
			nxt[k].prod = prod_n;
			nxt[k].bpb  = bpb_n;
			if (rem_w >= dsh) begin
				nxt[k].rem                 = NUM_W'(rem_w - dsh);
				nxt[k].quo[QUO_W - 1 - k]  = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[QUO_W-2:0], head_valid};
		end
	end

	assign oct_neg      = OCT_W'(0) - stg_s[QUO_W-1].oct;
	assign out_valid    = vld_s[QUO_W-1];
	assign pitch_word   = {oct_neg[OCT_FIELD_W-1:0], 1'b0, stg_s[QUO_W-1].quo[FNS_W-1:0]};
	assign frame_bytes  = stg_s[QUO_W-1].bpb;
	assign rate_too_low = stg_s[QUO_W-1].too_low;

endmodule
